[src/text_console_char_writer_assert.svh]
// Assertion macros shared by the console writer checker.
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
// Same-cycle implication, clocked on clk, quiet while in reset.
`define TCCW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");
// Next-cycle implication.
`define TCCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");
`endif

[src/tccw_pkg.sv]
// Package: constants, types and opcodes of the text console writer.
package tccw_pkg;
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(2 * CELLS + 2);
    localparam int COL_W  = $clog2(COLS);
    localparam int CUR_W  = 11;
    localparam int CODE_W = 9;
    localparam int TC_W   = 11;
    localparam int RA_W   = 11;
    localparam int DATA_W = 16;
    localparam int QDEPTH = 2;

    localparam logic [POS_W-1:0] CELLS_P    = POS_W'(CELLS);
    localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLS);
    localparam logic [POS_W-1:0] SCROLL_AT  = POS_W'((ROWS - 1) * COLS);
    localparam logic [POS_W-1:0] SCROLL_LEN = POS_W'((ROWS - 2) * COLS);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLS - 1);

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = CODE_W'(10);
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = CODE_W'(256);
    localparam logic [7:0]        ATTR_NORMAL    = 8'h07;
    localparam logic [DATA_W-1:0] BLANK_CELL     = 16'h0720;

    localparam logic OPC_PUT  = 1'b0;
    localparam logic OPC_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_READ,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CHAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [7:0]        chr;
        logic [TC_W-1:0]   tc;
        logic [RA_W-1:0]   addr;
    } work_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_COPY,
        S_PUTCHAR,
        S_CHECK,
        S_ZERO,
        S_BLANK,
        S_DONE
    } back_state_t;
endpackage

[src/tccw_if.sv]
// Channel interfaces: request and response, valid/ready handshake.
interface tccw_req_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [tccw_pkg::CODE_W-1:0] char_code;
    logic [tccw_pkg::TC_W-1:0]   trailing_cells;
    logic [tccw_pkg::RA_W-1:0]   read_address;
    modport source (output valid, opcode, char_code, trailing_cells, read_address,
                    input ready);
    modport sink   (input valid, opcode, char_code, trailing_cells, read_address,
                    output ready);
endinterface

interface tccw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tccw_pkg::CUR_W-1:0]  cursor_pos;
    logic                        fault;
    logic [tccw_pkg::DATA_W-1:0] cell_data;
    modport source (output valid, cursor_pos, fault, cell_data, input ready);
    modport sink   (input valid, cursor_pos, fault, cell_data, output ready);
endinterface

[src/tccw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[src/tccw_front.sv]
// Front end: accepts request transactions, classifies them, queues them.
module tccw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    tccw_req_if.sink             req,
    input  logic                 hold,
    input  logic                 pop,
    output logic                 q_valid,
    output tccw_pkg::work_item_t q_item
);
    import tccw_pkg::*;

    work_item_t           q_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;
    work_item_t           item;
    logic                 push;

    always_comb
    begin
        item.chr  = req.char_code[7:0];
        item.tc   = req.trailing_cells;
        item.addr = req.read_address;
        if (req.opcode == OPC_READ)
            item.kind = OP_READ;
        else if (req.char_code == CODE_NEWLINE)
            item.kind = OP_NEWLINE;
        else if (req.char_code == CODE_BACKSPACE)
            item.kind = OP_BACKSPACE;
        else
            item.kind = OP_CHAR;
    end

    assign req.ready = (cnt_reg < ($clog2(QDEPTH)+1)'(QDEPTH)) && !hold;
    assign push      = req.valid && req.ready;
    assign q_valid   = cnt_reg != '0;
    assign q_item    = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop && q_valid)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(QDEPTH)+1)'(push)
                               - ($clog2(QDEPTH)+1)'(pop && q_valid);
        end
    end
endmodule

[src/tccw_back.sv]
// Back end: sequencer that carries out queued items on the screen RAM.
module tccw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  tccw_pkg::work_item_t q_item,
    output logic                 pop,
    output logic                 clearing,
    tccw_rsp_if.source           rsp
);
    import tccw_pkg::*;

    back_state_t state_reg, state_next, after_reg, after_next;
    logic [POS_W-1:0]  pos_reg, pos_next, rd_reg, rd_next, wr_reg, wr_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next, clr_reg, clr_next;
    logic [POS_W-1:0]  pend_addr_reg, pend_addr_next;
    logic              pend_v_reg, pend_v_next, pend_zero_reg, pend_zero_next;
    logic              up_reg, up_next, rd_ok_reg, rd_ok_next;
    logic [COL_W-1:0]  pcol_reg, pcol_next, col_reg, col_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic              halted_reg, halted_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic [7:0]        chr_reg, chr_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              ov_reg, ov_next;
    logic [CUR_W-1:0]  ocur_reg, ocur_next;
    logic              ofault_reg, ofault_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    logic [POS_W-1:0]  cur_p, blank_at;

    tccw_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign cur_p    = POS_W'(cursor_reg);
    assign blank_at = pos_reg + POS_W'(tc_reg);
    assign clearing = state_reg == S_CLEAR;
    assign rsp.valid      = ov_reg;
    assign rsp.cursor_pos = ocur_reg;
    assign rsp.fault      = ofault_reg;
    assign rsp.cell_data  = odata_reg;

    always_comb
    begin
        state_next = state_reg;   after_next = after_reg;
        pos_next = pos_reg;       pcol_next = pcol_reg;
        rd_next = rd_reg;         wr_next = wr_reg;
        cnt_next = cnt_reg;       clr_next = clr_reg;
        pend_v_next = pend_v_reg; pend_addr_next = pend_addr_reg;
        pend_zero_next = pend_zero_reg;
        up_next = up_reg;         rd_ok_next = rd_ok_reg;
        col_next = col_reg;       cursor_next = cursor_reg;
        halted_next = halted_reg; tc_next = tc_reg;
        chr_next = chr_reg;       data_next = data_reg;
        ov_next = ov_reg && !rsp.ready;
        ocur_next = ocur_reg;     ofault_next = ofault_reg; odata_next = odata_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0; pop = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[ADDR_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELLS_P - 1'b1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    tc_next   = q_item.tc;
                    chr_next  = q_item.chr;
                    data_next = '0;
                    if (q_item.kind == OP_READ)
                    begin
                        raddr      = q_item.addr[ADDR_W-1:0];
                        rd_ok_next = POS_W'(q_item.addr) < CELLS_P;
                        state_next = S_RDWAIT;
                    end
                    else if (halted_reg)
                        state_next = S_DONE;
                    else if (q_item.kind == OP_NEWLINE)
                    begin
                        pos_next   = cur_p + COLS_P - POS_W'(col_reg);
                        pcol_next  = '0;
                        state_next = S_CHECK;
                    end
                    else if (q_item.kind == OP_BACKSPACE)
                    begin
                        up_next = 1'b1; pend_v_next = 1'b0;
                        after_next = S_CHECK; state_next = S_COPY;
                        if (cursor_reg != '0)
                        begin
                            rd_next   = cur_p;
                            wr_next   = cur_p - 1'b1;
                            cnt_next  = POS_W'(q_item.tc) + 1'b1;
                            pos_next  = cur_p - 1'b1;
                            pcol_next = (col_reg == '0) ? COL_LAST : col_reg - 1'b1;
                        end
                        else
                        begin
                            rd_next   = POS_W'(1);
                            wr_next   = '0;
                            cnt_next  = POS_W'(q_item.tc);
                            pos_next  = '0;
                            pcol_next = '0;
                        end
                    end
                    else
                    begin
                        // insert: shift trailing cells right, top down
                        up_next = 1'b0; pend_v_next = 1'b0;
                        rd_next  = cur_p + POS_W'(q_item.tc) - 1'b1;
                        wr_next  = cur_p + POS_W'(q_item.tc);
                        cnt_next = POS_W'(q_item.tc);
                        pos_next = cur_p;
                        pcol_next = col_reg;
                        after_next = S_PUTCHAR; state_next = S_COPY;
                    end
                end
            end
            S_RDWAIT:
            begin
                data_next  = rd_ok_reg ? rdata : '0;
                state_next = S_DONE;
            end
            S_COPY:
            begin
                if (pend_v_reg)
                begin
                    we    = pend_addr_reg < CELLS_P;
                    waddr = pend_addr_reg[ADDR_W-1:0];
                    wdata = pend_zero_reg ? '0 : rdata;
                end
                if (cnt_reg != '0)
                begin
                    raddr          = rd_reg[ADDR_W-1:0];
                    pend_v_next    = 1'b1;
                    pend_addr_next = wr_reg;
                    pend_zero_next = rd_reg >= CELLS_P;
                    rd_next  = up_reg ? rd_reg + 1'b1 : rd_reg - 1'b1;
                    wr_next  = up_reg ? wr_reg + 1'b1 : wr_reg - 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    pend_v_next = 1'b0;
                    if (!pend_v_reg)
                        state_next = after_reg;
                end
            end
            S_PUTCHAR:
            begin
                we    = pos_reg < CELLS_P;
                waddr = pos_reg[ADDR_W-1:0];
                wdata = {ATTR_NORMAL, chr_reg};
                pos_next   = pos_reg + 1'b1;
                pcol_next  = (pcol_reg == COL_LAST) ? '0 : pcol_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pos_reg > CELLS_P)
                begin
                    halted_next = 1'b1;
                    state_next  = S_DONE;
                end
                else if (pos_reg >= SCROLL_AT)
                begin
                    up_next = 1'b1; pend_v_next = 1'b0;
                    rd_next = COLS_P; wr_next = '0; cnt_next = SCROLL_LEN;
                    pos_next = pos_reg - COLS_P;
                    clr_next = pos_reg - COLS_P;
                    after_next = S_ZERO; state_next = S_COPY;
                end
                else
                    state_next = S_BLANK;
            end
            S_ZERO:
            begin
                if (clr_reg < SCROLL_AT)
                begin
                    we    = 1'b1;
                    waddr = clr_reg[ADDR_W-1:0];
                    clr_next = clr_reg + 1'b1;
                end
                else
                    state_next = S_BLANK;
            end
            S_BLANK:
            begin
                cursor_next = pos_reg[CUR_W-1:0];
                col_next    = pcol_reg;
                we    = blank_at < CELLS_P;
                waddr = blank_at[ADDR_W-1:0];
                wdata = BLANK_CELL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    ocur_next   = cursor_reg;
                    ofault_next = halted_reg;
                    odata_next  = data_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            after_reg  <= S_IDLE;
            clr_reg    <= '0;
            pend_v_reg <= 1'b0;
            cursor_reg <= '0;
            col_reg    <= '0;
            halted_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            clr_reg    <= clr_next;
            pend_v_reg <= pend_v_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            halted_reg <= halted_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;       pcol_reg <= pcol_next;
        rd_reg <= rd_next;         wr_reg <= wr_next;
        cnt_reg <= cnt_next;       pend_addr_reg <= pend_addr_next;
        pend_zero_reg <= pend_zero_next;
        up_reg <= up_next;         rd_ok_reg <= rd_ok_next;
        tc_reg <= tc_next;         chr_reg <= chr_next;
        data_reg <= data_next;
        ocur_reg <= ocur_next;     ofault_reg <= ofault_next;
        odata_reg <= odata_next;
    end
endmodule

[src/text_console_char_writer.sv]
// Top level of the text console writer: front queue plus execution back end.
// An 80x25 screen of 16-bit cells (attribute high byte, character low byte)
// held in one RAM, with a cursor. Each request transaction gives exactly one
// response transaction. After reset the block sweeps the RAM to zero, one
// cell a cycle, and holds req.ready low meanwhile. A character or a
// backspace moves its trailing cells one per cycle through the RAM's
// single write port. A put that reaches the last row also scrolls: 1840
// cell moves plus up to 80 cleared cells. Up to two requests queue in the
// front end while the back end works, and one response waits in the output
// register, so the two sides stall independently. Once a fault is flagged,
// puts are ignored and reads still work.
module text_console_char_writer (
    input logic      clk,
    input logic      rst_n,
    tccw_req_if.sink   req,
    tccw_rsp_if.source rsp
);
    import tccw_pkg::*;

    work_item_t q_item;
    logic       q_valid;
    logic       pop;
    logic       clearing;

    // front: handshake, classification, two-entry queue
    tccw_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .hold(clearing),
        .pop(pop), .q_valid(q_valid), .q_item(q_item)
    );

    // back: screen RAM sequencer and response register
    tccw_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .pop(pop), .clearing(clearing), .rsp(rsp)
    );
endmodule

[src/tccw_checker.sv]
// Port-level checker for the text console writer, with its bind.
`include "text_console_char_writer_assert.svh"
module tccw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_fault,
    input logic [tccw_pkg::CUR_W-1:0]  rsp_cursor_pos
);
    import tccw_pkg::*;

    logic fault_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fault_seen_reg <= 1'b0;
        else if (rsp_valid && rsp_ready && rsp_fault)
            fault_seen_reg <= 1'b1;
    end

    `TCCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `TCCW_ASSERT_IMPLY(a_fault_sticky, rsp_valid && fault_seen_reg, rsp_fault)
    `TCCW_ASSERT_IMPLY(a_cursor_row, rsp_valid && !rsp_fault,
        POS_W'(rsp_cursor_pos) < SCROLL_AT)
endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
    .clk(clk), .rst_n(rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_fault(rsp.fault), .rsp_cursor_pos(rsp.cursor_pos)
);

[verif/console_writer_checker.sv]
// Checker for the console writer: tracks screen state and compares responses.
`timescale 1ns / 100ps

module console_writer_checker
    import tccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tccw_req_if        req,
    tccw_rsp_if        rsp,
    output int         errors,
    output int         pending
);

    typedef struct {
        logic [CUR_W-1:0]  cursor_pos;
        logic              fault;
        logic [DATA_W-1:0] cell_data;
    } console_result_t;

    logic [DATA_W-1:0] shadow_screen [CELLS];
    int                shadow_cursor;
    logic              shadow_halted;
    console_result_t   awaited_q [$];

    function automatic logic [DATA_W-1:0] peek_cell(int idx);
        return (idx < CELLS) ? shadow_screen[idx] : '0;
    endfunction

    function automatic void poke_cell(int idx, logic [DATA_W-1:0] v);
        if (idx < CELLS)
            shadow_screen[idx] = v;
    endfunction

    // Apply one put transaction to the shadow screen and cursor.
    function automatic void apply_put(logic [CODE_W-1:0] code, int tc);
        int pos;
        int start;
        pos = shadow_cursor;
        if (code == CODE_NEWLINE)
        begin
            pos += COLS - pos % COLS;
        end
        else if (code == CODE_BACKSPACE)
        begin
            start = (pos > 0) ? pos - 1 : 0;
            for (int i = start; i < pos + tc; i++)
                poke_cell(i, peek_cell(i + 1));
            if (pos > 0)
                pos--;
        end
        else
        begin
            for (int i = pos + tc; i > pos; i--)
                poke_cell(i, peek_cell(i - 1));
            poke_cell(pos, {ATTR_NORMAL, code[7:0]});
            pos++;
        end
        if (pos > CELLS)
        begin
            shadow_halted = 1'b1;
            return;
        end
        // Scroll rows up once the cursor lands on the last row
        if (pos / COLS >= ROWS - 1)
        begin
            for (int i = 0; i < (ROWS - 2) * COLS; i++)
                shadow_screen[i] = shadow_screen[i + COLS];
            pos -= COLS;
            for (int i = pos; i < (ROWS - 1) * COLS; i++)
                shadow_screen[i] = '0;
        end
        shadow_cursor = pos;
        poke_cell(pos + tc, BLANK_CELL);
    endfunction

    assign pending = awaited_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t r;
        console_result_t e;
        if (!rst_n)
        begin
            foreach (shadow_screen[i])
                shadow_screen[i] = '0;
            shadow_cursor = 0;
            shadow_halted = 1'b0;
            awaited_q.delete();
            errors = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                r.cell_data = '0;
                if (req.opcode == OPC_READ)
                    r.cell_data = peek_cell(int'(req.read_address));
                else if (!shadow_halted)
                    apply_put(req.char_code, int'(req.trailing_cells));
                r.cursor_pos = CUR_W'(shadow_cursor);
                r.fault      = shadow_halted;
                awaited_q.push_back(r);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: unexpected response cursor %0d fault %0d data %h",
                             $time, rsp.cursor_pos, rsp.fault, rsp.cell_data);
                    errors++;
                end
                else
                begin
                    e = awaited_q.pop_front();
                    if (rsp.cursor_pos !== e.cursor_pos)
                    begin
                        $display("%0t: cursor_pos expected %0d actual %0d",
                                 $time, e.cursor_pos, rsp.cursor_pos);
                        errors++;
                    end
                    if (rsp.fault !== e.fault)
                    begin
                        $display("%0t: fault expected %0d actual %0d",
                                 $time, e.fault, rsp.fault);
                        errors++;
                    end
                    if (rsp.cell_data !== e.cell_data)
                    begin
                        $display("%0t: cell_data expected %h actual %h",
                                 $time, e.cell_data, rsp.cell_data);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[verif/testbench.sv]
// Top of the console writer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import tccw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    logic rsp_quiet;     // when set, the response side never stalls
    int   rsp_stall;

    tccw_req_if req ();
    tccw_rsp_if rsp ();

    text_console_char_writer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    console_writer_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        else if (roll < 94)
            return $urandom_range(3, 1);
        else
            return $urandom_range(60, 10);
    endfunction

    // Response-side back-pressure; a stall counter drops ready for a while
    always @(posedge clk)
    begin
        if (!rst_n || rsp_quiet)
            rsp.ready <= 1'b1;
        else if (rsp_stall > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if ($urandom_range(3) == 0)
                rsp_stall <= pick_gap();
        end
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // One request transaction, preceded by a random gap with valid low.
    // Ready is looked at mid-cycle, so the next rising edge is the accepting one.
    task automatic send_request(logic op, logic [CODE_W-1:0] code,
                                logic [TC_W-1:0] tc, logic [RA_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.opcode         <= op;
        req.char_code      <= code;
        req.trailing_cells <= tc;
        req.read_address   <= addr;
        @(negedge clk);
        while (!req.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Trailing count: usually a short line, occasionally anything at all
    function automatic logic [TC_W-1:0] pick_trailing();
        if ($urandom_range(19) == 0)
            return TC_W'($urandom_range(2047));
        return TC_W'($urandom_range(40));
    endfunction

    task automatic send_random_item();
        int roll;
        logic [CODE_W-1:0] code;
        logic [RA_W-1:0]   addr;
        roll = $urandom_range(99);
        addr = ($urandom_range(9) == 0) ? RA_W'($urandom_range(2047))
                                        : RA_W'($urandom_range(CELLS - 1));
        if (roll < 30)
            send_request(OPC_READ, CODE_W'($urandom), pick_trailing(), addr);
        else
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                code = CODE_NEWLINE;
            else if (roll < 45)
                code = CODE_BACKSPACE;
            else
                code = CODE_W'($urandom_range(511));
            send_request(OPC_PUT, code, pick_trailing(), addr);
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req.valid          <= 1'b0;
        req.opcode         <= OPC_PUT;
        req.char_code      <= '0;
        req.trailing_cells <= '0;
        req.read_address   <= '0;
        rsp_quiet          <= 1'b0;
        rsp_stall          <= 0;
        idle_cycles        <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, both ops, backspace at cell 0,
        // over-wide codes, out-of-range reads, huge trailing counts
        send_request(OPC_READ, '0, '0, '0);
        send_request(OPC_READ, '1, '1, RA_W'(CELLS - 1));
        send_request(OPC_READ, '0, '0, '1);
        send_request(OPC_PUT, CODE_BACKSPACE, '0, '0);
        send_request(OPC_PUT, CODE_BACKSPACE, TC_W'(5), '0);
        send_request(OPC_PUT, CODE_W'(0), '0, '0);
        send_request(OPC_PUT, CODE_W'(255), TC_W'(3), '0);
        send_request(OPC_PUT, '1, TC_W'(2), '1);
        send_request(OPC_PUT, CODE_W'(257), '0, '0);
        send_request(OPC_PUT, CODE_NEWLINE, '0, '0);
        send_request(OPC_PUT, CODE_W'(65), TC_W'(CELLS), '0);
        send_request(OPC_PUT, CODE_BACKSPACE, '1, '0);
        send_request(OPC_PUT, CODE_W'(66), '1, '0);
        send_request(OPC_READ, '0, '0, RA_W'(CELLS));
        send_request(OPC_READ, '0, '0, RA_W'(1));
        send_request(OPC_READ, '0, '0, RA_W'(2));
        // Newline run towards the bottom so scrolling starts early
        repeat (8)
            send_request(OPC_PUT, CODE_NEWLINE, TC_W'($urandom_range(3)), '0);

        // Random phase; the middle third runs with no response stalls
        for (int n = 0; n < 300; n++)
        begin
            rsp_quiet <= (n >= 100 && n < 200);
            send_random_item();
        end
        req.valid <= 1'b0;
        rsp_quiet <= 1'b0;

        // let the checker log the last transaction before polling
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/tccw_pkg.sv
src/tccw_if.sv
src/tccw_ram.sv
src/tccw_front.sv
src/tccw_back.sv
src/text_console_char_writer.sv
src/tccw_checker.sv
verif/console_writer_checker.sv
verif/testbench.sv
